// ===== src/hsp_pkg.sv =====
// Shared types, constants and register indexes of the hall sensor position counter.
package hsp_pkg;

    // Datapath widths
    localparam int unsigned SAMPLE_WIDTH   = 12;
    localparam int unsigned POSITION_WIDTH = 32;
    localparam int unsigned LIMIT_WIDTH    = 12;
    localparam int unsigned TABLE_WIDTH    = 18;
    localparam int unsigned CFG_DATA_WIDTH = 18;
    localparam int unsigned OUT_POS_WIDTH  = 32;

    // Register reset values
    localparam logic [LIMIT_WIDTH-1:0] RANGE_LIMIT_RST    = 12'd1200;
    localparam logic [LIMIT_WIDTH-1:0] HIGH_THRESHOLD_RST = 12'd100;
    localparam logic [TABLE_WIDTH-1:0] SEQ_TABLE_RST      = 18'd120912;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_RANGE_LIMIT    = 2'd0,
        CFG_HIGH_THRESHOLD = 2'd1,
        CFG_SEQ_TABLE      = 2'd2,
        CFG_REVERSE_SPIN   = 2'd3
    } t_cfg_index;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_RANGE   = 2'd1,
        ST_INVALID = 2'd2,
        ST_JUMP    = 2'd3
    } t_status;

    // Step codes, two's complement
    localparam logic [1:0] STEP_ZERO = 2'b00;
    localparam logic [1:0] STEP_UP   = 2'b01;
    localparam logic [1:0] STEP_DOWN = 2'b11;

    // Sequence index values that bound the wrap
    localparam logic [2:0] IDX_FIRST = 3'd0;
    localparam logic [2:0] IDX_LAST  = 3'd5;

    // Hall codes with all sensors equal
    localparam logic [2:0] CODE_ALL_LOW  = 3'b000;
    localparam logic [2:0] CODE_ALL_HIGH = 3'b111;

    // Configuration seen by the decoder
    typedef struct packed {
        logic [LIMIT_WIDTH-1:0] range_limit;
        logic [LIMIT_WIDTH-1:0] high_threshold;
        logic [TABLE_WIDTH-1:0] seq_table;
        logic                   reverse_spin;
    } t_cfg;

    // Decoder outcome for one request
    typedef struct packed {
        logic       upd_index;
        logic [2:0] index;
        logic [1:0] step;
        t_status    status;
    } t_dec;

endpackage

// ===== src/hall_sensor_position_counter_core.sv =====
// Top level of the hall sensor position counter: registers, state and handshakes.
// A request is held in the input register, then decoded and added into the result register.
// Throughput: one request per cycle while the receiver takes results; set by the single decode and add stage
// between the input register and the result register.
// Reset (synchronous, active low) clears valid flags, position and last index,
// and loads the configuration registers with their default values.
module hall_sensor_position_counter_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [1:0]                          i_cfg_index,
    input  logic [hsp_pkg::CFG_DATA_WIDTH-1:0]  i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [hsp_pkg::SAMPLE_WIDTH-1:0]    i_sample_a,
    input  logic [hsp_pkg::SAMPLE_WIDTH-1:0]    i_sample_b,
    input  logic [hsp_pkg::SAMPLE_WIDTH-1:0]    i_sample_c,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [hsp_pkg::OUT_POS_WIDTH-1:0] o_position,
    output logic signed [1:0]                   o_step,
    output logic [1:0]                          o_status
);
    import hsp_pkg::*;

    localparam int unsigned EXT_WIDTH =
        (POSITION_WIDTH > OUT_POS_WIDTH) ? POSITION_WIDTH : OUT_POS_WIDTH;

    t_cfg                       r_cfg;
    logic                       r_in_valid;
    logic [SAMPLE_WIDTH-1:0]    r_a, r_b, r_c;
    logic [2:0]                 r_last_index;
    logic [POSITION_WIDTH-1:0]  r_count, n_count;
    logic                       r_out_valid;
    logic [OUT_POS_WIDTH-1:0]   r_position;
    logic [1:0]                 r_step;
    t_status                    r_status;
    t_dec                       w_dec;
    logic                       w_advance;
    logic [EXT_WIDTH-1:0]       w_pos_ext;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.range_limit    <= RANGE_LIMIT_RST;
            r_cfg.high_threshold <= HIGH_THRESHOLD_RST;
            r_cfg.seq_table      <= SEQ_TABLE_RST;
            r_cfg.reverse_spin   <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_RANGE_LIMIT:    r_cfg.range_limit    <= i_cfg_data[LIMIT_WIDTH-1:0];
                CFG_HIGH_THRESHOLD: r_cfg.high_threshold <= i_cfg_data[LIMIT_WIDTH-1:0];
                CFG_SEQ_TABLE:      r_cfg.seq_table      <= i_cfg_data[TABLE_WIDTH-1:0];
                CFG_REVERSE_SPIN:   r_cfg.reverse_spin   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Handshake: move a request on when the result register is free or drains
    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_a <= i_sample_a;
            r_b <= i_sample_b;
            r_c <= i_sample_c;
        end
    end

    hsp_decode u_decode (
        .i_sample_a   (r_a),
        .i_sample_b   (r_b),
        .i_sample_c   (r_c),
        .i_cfg        (r_cfg),
        .i_last_index (r_last_index),
        .o_dec        (w_dec)
    );

    // Position update, step sign-extended
    assign n_count   = r_count + {{(POSITION_WIDTH-2){w_dec.step[1]}}, w_dec.step};
    assign w_pos_ext = EXT_WIDTH'(n_count);

    // State
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_index <= 3'd0;
            r_count      <= '0;
        end else if (w_advance) begin
            r_count <= n_count;
            if (w_dec.upd_index) begin
                r_last_index <= w_dec.index;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_position <= w_pos_ext[OUT_POS_WIDTH-1:0];
            r_step     <= w_dec.step;
            r_status   <= w_dec.status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_position  = r_position;
    assign o_step      = r_step;
    assign o_status    = r_status;

endmodule

// ===== src/hsp_decode.sv =====
// Classifies one set of hall samples and works out the step against the last index.
module hsp_decode (
    input  logic [hsp_pkg::SAMPLE_WIDTH-1:0] i_sample_a,
    input  logic [hsp_pkg::SAMPLE_WIDTH-1:0] i_sample_b,
    input  logic [hsp_pkg::SAMPLE_WIDTH-1:0] i_sample_c,
    input  hsp_pkg::t_cfg                    i_cfg,
    input  logic [2:0]                       i_last_index,
    output hsp_pkg::t_dec                    o_dec
);
    import hsp_pkg::*;

    localparam int unsigned CW = (SAMPLE_WIDTH > LIMIT_WIDTH) ? SAMPLE_WIDTH : LIMIT_WIDTH;

    logic [CW-1:0] w_a, w_b, w_c, w_lim, w_thr;
    logic          w_range_err;
    logic [2:0]    w_code;
    logic [2:0]    w_idx;
    logic [3:0]    w_idx_ext, w_last_ext;
    logic          w_fwd, w_bwd;
    logic [1:0]    w_raw_step;

    // Common compare width
    assign w_a   = CW'(i_sample_a);
    assign w_b   = CW'(i_sample_b);
    assign w_c   = CW'(i_sample_c);
    assign w_lim = CW'(i_cfg.range_limit);
    assign w_thr = CW'(i_cfg.high_threshold);

    // Range check and thresholding
    assign w_range_err = (w_a > w_lim) || (w_b > w_lim) || (w_c > w_lim);
    assign w_code      = {w_a > w_thr, w_b > w_thr, w_c > w_thr};

    // Table lookup, code k takes field k-1
    always_comb begin
        case (w_code)
            3'd1:    w_idx = i_cfg.seq_table[2:0];
            3'd2:    w_idx = i_cfg.seq_table[5:3];
            3'd3:    w_idx = i_cfg.seq_table[8:6];
            3'd4:    w_idx = i_cfg.seq_table[11:9];
            3'd5:    w_idx = i_cfg.seq_table[14:12];
            3'd6:    w_idx = i_cfg.seq_table[17:15];
            default: w_idx = 3'd0;
        endcase
    end

    // One step forward in the index gives a down count, and the reverse;
    // a difference of five either way counts as the wrap step
    assign w_idx_ext  = {1'b0, w_idx};
    assign w_last_ext = {1'b0, i_last_index};
    assign w_fwd = (w_idx_ext == w_last_ext + 4'd1)
                || (w_last_ext == w_idx_ext + 4'd5);
    assign w_bwd = (w_last_ext == w_idx_ext + 4'd1)
                || (w_idx_ext == w_last_ext + 4'd5);

    always_comb begin
        if (w_fwd) begin
            w_raw_step = STEP_DOWN;
        end else if (w_bwd) begin
            w_raw_step = STEP_UP;
        end else begin
            w_raw_step = STEP_ZERO;
        end
    end

    // Outcome
    always_comb begin
        o_dec.index     = w_idx;
        o_dec.upd_index = 1'b0;
        o_dec.step      = STEP_ZERO;
        o_dec.status    = ST_OK;
        if (w_range_err) begin
            o_dec.status = ST_RANGE;
        end else if (w_code == CODE_ALL_LOW || w_code == CODE_ALL_HIGH) begin
            o_dec.status = ST_INVALID;
        end else begin
            o_dec.upd_index = 1'b1;
            if (w_idx != i_last_index && w_raw_step == STEP_ZERO) begin
                o_dec.status = ST_JUMP;
            end
            // negation of -1/+1 in two bits
            o_dec.step = i_cfg.reverse_spin ? (2'b00 - w_raw_step) : w_raw_step;
        end
    end

endmodule

// ===== test/tb.sv =====
// Testbench of the hall sensor position counter: directed and random hall requests.
module tb;
    import hsp_pkg::*;

    localparam int RX_HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES   = 8;
    localparam int CHUNK          = 40;

    typedef struct {
        logic [SAMPLE_WIDTH-1:0] a;
        logic [SAMPLE_WIDTH-1:0] b;
        logic [SAMPLE_WIDTH-1:0] c;
    } t_hall_reading;

    typedef struct {
        logic [OUT_POS_WIDTH-1:0] position;
        logic [1:0]               step;
        t_status                  status;
    } t_hall_result;

    // DUT ports, all inputs driven from time zero
    logic                        i_clk       = 1'b0;
    logic                        i_rst_n     = 1'b0;
    logic                        i_cfg_we    = 1'b0;
    logic [1:0]                  i_cfg_index = CFG_RANGE_LIMIT;
    logic [CFG_DATA_WIDTH-1:0]   i_cfg_data  = '0;
    logic                        i_in_valid  = 1'b0;
    logic                        o_in_ready;
    logic [SAMPLE_WIDTH-1:0]     i_sample_a  = '0;
    logic [SAMPLE_WIDTH-1:0]     i_sample_b  = '0;
    logic [SAMPLE_WIDTH-1:0]     i_sample_c  = '0;
    logic                        o_out_valid;
    logic                        i_out_ready = 1'b0;
    logic signed [OUT_POS_WIDTH-1:0] o_position;
    logic signed [1:0]           o_step;
    logic [1:0]                  o_status;

    // Local copy of the configuration and decoder state
    logic [LIMIT_WIDTH-1:0]      lim_cfg    = RANGE_LIMIT_RST;
    logic [LIMIT_WIDTH-1:0]      thr_cfg    = HIGH_THRESHOLD_RST;
    logic [TABLE_WIDTH-1:0]      seq_cfg    = SEQ_TABLE_RST;
    logic                        rev_cfg    = 1'b0;
    logic [2:0]                  last_idx   = IDX_FIRST;
    logic [OUT_POS_WIDTH-1:0]    step_total = '0;

    t_hall_reading sample_queue[$];
    t_hall_result  due_results[$];

    // Stimulus steering and statistics
    logic [2:0] gen_index      = IDX_FIRST;
    int         idle_turn      = 0;
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    int         hold_req       = 0;
    int         hold_served    = 0;
    int         rx_hold_left   = 0;
    int         n_errors       = 0;
    int         n_accepted     = 0;
    int         n_checked      = 0;
    int         n_cfg_writes   = 0;
    int         n_in_stalls    = 0;

    hall_sensor_position_counter_core u_dut (.*);

    // Clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic flag_mismatch(string what);
        $display("MISMATCH at %0t: %s", $time, what);
        n_errors++;
    endtask

    // Decode one accepted request and queue the result it should produce
    function automatic void decode_hall_reading(logic [SAMPLE_WIDTH-1:0] a,
                                                logic [SAMPLE_WIDTH-1:0] b,
                                                logic [SAMPLE_WIDTH-1:0] c);
        t_hall_result r;
        logic [2:0]   code;
        logic [2:0]   idx;
        int           diff;
        r.step = STEP_ZERO;
        if (a > lim_cfg || b > lim_cfg || c > lim_cfg) begin
            r.status = ST_RANGE;
        end else begin
            code = {a > thr_cfg, b > thr_cfg, c > thr_cfg};
            if (code == CODE_ALL_LOW || code == CODE_ALL_HIGH) begin
                r.status = ST_INVALID;
            end else begin
                idx  = seq_cfg[3*(code-1) +: 3];
                diff = int'(idx) - int'(last_idx);
                r.status = ST_OK;
                // index forward counts down; the 5 to 0 and 0 to 5 wraps follow suit
                if (diff == 1 || diff == -5)
                    r.step = STEP_DOWN;
                else if (diff == -1 || diff == 5)
                    r.step = STEP_UP;
                else if (diff != 0)
                    r.status = ST_JUMP;
                if (rev_cfg) begin
                    if (r.step == STEP_UP)
                        r.step = STEP_DOWN;
                    else if (r.step == STEP_DOWN)
                        r.step = STEP_UP;
                end
                if (r.step == STEP_UP)
                    step_total = step_total + 1'b1;
                else if (r.step == STEP_DOWN)
                    step_total = step_total - 1'b1;
                last_idx = idx;
            end
        end
        r.position = step_total;
        due_results.push_back(r);
    endfunction

    function automatic void push_reading(logic [SAMPLE_WIDTH-1:0] a,
                                         logic [SAMPLE_WIDTH-1:0] b,
                                         logic [SAMPLE_WIDTH-1:0] c);
        t_hall_reading r;
        r.a = a;
        r.b = b;
        r.c = c;
        sample_queue.push_back(r);
    endfunction

    // Sample level that reads as the given sensor bit under the current settings
    function automatic logic [SAMPLE_WIDTH-1:0] level_for(logic hi);
        if (hi) begin
            if (thr_cfg < lim_cfg)
                return SAMPLE_WIDTH'($urandom_range(int'(lim_cfg), int'(thr_cfg) + 1));
            return SAMPLE_WIDTH'($urandom);
        end
        return SAMPLE_WIDTH'($urandom_range(thr_cfg <= lim_cfg ? int'(thr_cfg)
                                                                : int'(lim_cfg), 0));
    endfunction

    function automatic logic [SAMPLE_WIDTH-1:0] noise_level();
        if ($urandom_range(1))
            return SAMPLE_WIDTH'($urandom);
        return SAMPLE_WIDTH'($urandom_range(int'(lim_cfg), 0));
    endfunction

    function automatic void push_code(logic [2:0] code);
        push_reading(level_for(code[2]), level_for(code[1]), level_for(code[0]));
    endfunction

    // Pick a hall code whose table entry is the wanted index, any valid code if none
    function automatic logic [2:0] code_for_index(logic [2:0] target);
        logic [2:0] hits[$];
        for (int k = 1; k <= 6; k++)
            if (seq_cfg[3*(k-1) +: 3] == target)
                hits.push_back(3'(k));
        if (hits.size() == 0)
            return 3'($urandom_range(6, 1));
        return hits[$urandom_range(hits.size() - 1, 0)];
    endfunction

    function automatic void set_idling(int turn);
        case (turn % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
            default: begin send_idle_pct = 28; recv_stall_pct = 28; end
        endcase
    endfunction

    // Wait until every request is taken and every result is back
    task automatic settle();
        while (sample_queue.size() != 0 || i_in_valid || due_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_index idx, logic [CFG_DATA_WIDTH-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_RANGE_LIMIT:    lim_cfg = value[LIMIT_WIDTH-1:0];
            CFG_HIGH_THRESHOLD: thr_cfg = value[LIMIT_WIDTH-1:0];
            CFG_SEQ_TABLE:      seq_cfg = value[TABLE_WIDTH-1:0];
            default:            rev_cfg = value[0];
        endcase
        n_cfg_writes++;
    endtask

    // Mostly neighbouring steps through the sequence, with repeats, jumps, all-equal codes and noise
    task automatic run_random(int n);
        int            pick;
        logic [2:0]    code;
        logic [2:0]    target;
        t_hall_reading r;
        for (int i = 0; i < n; i++) begin
            if (i % CHUNK == 0) begin
                while (sample_queue.size() != 0) @(posedge i_clk);
                set_idling(idle_turn);
                idle_turn++;
            end
            pick = $urandom_range(99);
            if (pick >= 92) begin
                push_reading(noise_level(), noise_level(), noise_level());
                continue;
            end
            if (pick < 65) begin
                if (gen_index > IDX_LAST)
                    target = 3'($urandom_range(7, 0));
                else if ($urandom_range(1))
                    target = (gen_index == IDX_LAST) ? IDX_FIRST : 3'(gen_index + 3'd1);
                else
                    target = (gen_index == IDX_FIRST) ? IDX_LAST : 3'(gen_index - 3'd1);
                code = code_for_index(target);
            end else if (pick < 75) begin
                code = code_for_index(gen_index);
            end else if (pick < 85) begin
                code = 3'($urandom_range(6, 1));
            end else begin
                code = $urandom_range(1) ? CODE_ALL_LOW : CODE_ALL_HIGH;
            end
            push_code(code);
            if (code != CODE_ALL_LOW && code != CODE_ALL_HIGH)
                gen_index = seq_cfg[3*(code-1) +: 3];
        end
    endtask

    // Request driver
    always @(posedge i_clk) begin : drive_requests
        t_hall_reading nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                decode_hall_reading(i_sample_a, i_sample_b, i_sample_c);
                n_accepted++;
            end
            if (i_in_valid && !o_in_ready)
                n_in_stalls++;
            if (!i_in_valid || o_in_ready) begin
                if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = sample_queue.pop_front();
                    i_in_valid <= 1'b1;
                    i_sample_a <= nxt.a;
                    i_sample_b <= nxt.b;
                    i_sample_c <= nxt.c;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here
    always @(posedge i_clk) begin
        if (hold_served != hold_req) begin
            hold_served  <= hold_req;
            rx_hold_left <= RX_HOLD_CYCLES;
        end else if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
        end
    end

    // Result monitor
    always @(posedge i_clk) begin : check_results
        t_hall_result want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (due_results.size() == 0) begin
                    flag_mismatch("result with no request outstanding");
                end else begin
                    want = due_results.pop_front();
                    n_checked++;
                    if (o_position !== want.position)
                        flag_mismatch($sformatf("position %0d, expected %0d",
                                                o_position, $signed(want.position)));
                    if (o_step !== want.step)
                        flag_mismatch($sformatf("step %0d, expected %0d",
                                                o_step, $signed(want.step)));
                    if (o_status !== want.status)
                        flag_mismatch($sformatf("status %0d, expected %0d",
                                                o_status, want.status));
                end
            end
            i_out_ready <= (rx_hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Stimulus and configuration sequence
    initial begin
        logic [2:0] perm[6];
        logic [2:0] tmp;
        int         j;
        int         thr_pick;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed requests under the reset settings
        push_reading(12'd0, 12'd0, 12'd0);
        push_reading(12'd1200, 12'd1200, 12'd1200);
        push_reading(12'd1201, 12'd0, 12'd0);
        push_reading(12'd0, 12'd1201, 12'd0);
        push_reading(12'd0, 12'd0, 12'd4095);
        push_reading(12'd4095, 12'd4095, 12'd4095);
        // exactly at threshold reads low: code 1, same index as reset, no step
        push_reading(12'd100, 12'd100, 12'd101);
        // forward through the sequence and across the 5 to 0 wrap
        push_code(3'd3);
        push_code(3'd2);
        push_code(3'd6);
        push_code(3'd4);
        push_code(3'd5);
        push_code(3'd1);
        // back across the 0 to 5 wrap
        push_code(3'd5);
        push_code(3'd4);
        // illegal jumps, then a repeat of the new index
        push_code(3'd1);
        push_code(3'd6);
        push_code(3'd6);
        // out of range wins over a valid code
        push_reading(12'd1201, 12'd101, 12'd0);
        push_reading(12'd101, 12'd101, 12'd101);
        gen_index = 3'd3;
        run_random(160);

        // Whole range accepted, zero threshold, reverse spin; upper data bits ignored
        settle();
        write_reg(CFG_RANGE_LIMIT, 18'h3FFFF);
        write_reg(CFG_HIGH_THRESHOLD, 18'h3F000);
        write_reg(CFG_REVERSE_SPIN, 18'h15555);
        run_random(180);

        // Table with entries 6 and 7
        settle();
        write_reg(CFG_SEQ_TABLE, {3'd2, 3'd1, 3'd0, 3'd5, 3'd7, 3'd6});
        write_reg(CFG_RANGE_LIMIT, 18'd3000);
        write_reg(CFG_HIGH_THRESHOLD, 18'd1500);
        write_reg(CFG_REVERSE_SPIN, 18'h3FFFE);
        run_random(160);

        // Random table and levels
        settle();
        thr_pick = $urandom_range(1500, 0);
        write_reg(CFG_SEQ_TABLE, CFG_DATA_WIDTH'($urandom));
        write_reg(CFG_HIGH_THRESHOLD, CFG_DATA_WIDTH'(thr_pick));
        write_reg(CFG_RANGE_LIMIT, CFG_DATA_WIDTH'($urandom_range(4095, thr_pick + 500)));
        write_reg(CFG_REVERSE_SPIN, 18'd1);
        run_random(160);

        // Extremes: nothing in range above zero, then nothing ever reads high
        settle();
        write_reg(CFG_RANGE_LIMIT, 18'd0);
        write_reg(CFG_HIGH_THRESHOLD, 18'd0);
        run_random(40);
        settle();
        write_reg(CFG_RANGE_LIMIT, 18'd4095);
        write_reg(CFG_HIGH_THRESHOLD, 18'd4095);
        run_random(40);

        // Receiver holds off while the sender keeps offering requests
        settle();
        write_reg(CFG_RANGE_LIMIT, CFG_DATA_WIDTH'(RANGE_LIMIT_RST));
        write_reg(CFG_HIGH_THRESHOLD, CFG_DATA_WIDTH'(HIGH_THRESHOLD_RST));
        write_reg(CFG_SEQ_TABLE, SEQ_TABLE_RST);
        write_reg(CFG_REVERSE_SPIN, 18'd0);
        set_idling(0);
        @(posedge i_clk);
        hold_req <= hold_req + 1;
        repeat (80) push_code(3'($urandom_range(6, 1)));

        // Random permutation table, random spin direction
        settle();
        perm = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5};
        for (int i = 5; i > 0; i--) begin
            j       = $urandom_range(i, 0);
            tmp     = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
        end
        write_reg(CFG_SEQ_TABLE, {perm[5], perm[4], perm[3], perm[2], perm[1], perm[0]});
        write_reg(CFG_REVERSE_SPIN, CFG_DATA_WIDTH'($urandom));
        gen_index = perm[0];
        run_random(280);

        settle();
        $display("Run covered %0d requests and %0d checked results over %0d register writes.",
                 n_accepted, n_checked, n_cfg_writes);
        $display("Input back-pressure seen on %0d cycles; %0d mismatches.",
                 n_in_stalls, n_errors);
        if (n_errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Run limit
    initial begin
        #2000000;
        $display("Timeout with %0d results still outstanding", due_results.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
src/hsp_pkg.sv
src/hsp_decode.sv
src/hall_sensor_position_counter_core.sv
test/tb.sv
